### src/point_rotate_crop_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point rotate and crop filter
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_CROP_FILTER_UNIT_ASSERT_SVH
`define POINT_ROTATE_CROP_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must hold in the same cycle as the trigger.
`define PRCF_ASSERT_SAME(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("prcf: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define PRCF_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("prcf: next-cycle check failed");

`else

`define PRCF_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define PRCF_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

### src/prcf_pkg.sv
// ----------------------------------------------------------------------------
// prcf_pkg
// Shared types and constants of the point rotate and crop filter.
// ----------------------------------------------------------------------------
package prcf_pkg;

	localparam int INTEN_BITS   = 16;
	localparam int NUM_REGS     = 8;
	localparam int REG_IDX_BITS = 3;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_INTENSITY_MIN = 3'd0,
		REG_ROTATION_COS  = 3'd1,
		REG_ROTATION_SIN  = 3'd2,
		REG_X_LIMIT       = 3'd3,
		REG_Y_LOW         = 3'd4,
		REG_Y_HIGH        = 3'd5,
		REG_INNER_TOP     = 3'd6,
		REG_INNER_BOT     = 3'd7
	} cfg_reg_t;

	// Load enables of the rotation datapath stages.
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

### src/prcf_if.sv
// ----------------------------------------------------------------------------
// prcf channel interfaces
// Valid/ready channels for input points, results and register writes.
// ----------------------------------------------------------------------------
interface prcf_point_if #(
	parameter int COORD_BITS = 24
);
	import prcf_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic        [INTEN_BITS-1:0] strength;

	modport source (output valid, pos_x, pos_y, pos_z, strength, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, strength, output ready);
endinterface

interface prcf_result_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] rot_x;
	logic signed [COORD_BITS-1:0] rot_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic                         keep;

	modport source (output valid, rot_x, rot_y, out_z, keep, input ready);
	modport sink   (input valid, rot_x, rot_y, out_z, keep, output ready);
endinterface

interface prcf_cfg_if #(
	parameter int DATA_BITS = 24
);
	import prcf_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [REG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]    wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface

### src/prcf_rotate.sv
// ----------------------------------------------------------------------------
// prcf_rotate
// Two-stage z-axis rotation: registered products, then floor shift and
// saturation to the coordinate range.
// ----------------------------------------------------------------------------
module prcf_rotate
	import prcf_pkg::*;
#(
	parameter int COORD_BITS     = 24,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                             clk,
	input  stage_en_t                        en,
	input  logic signed [TRIG_FRAC_BITS+1:0] rot_cos,
	input  logic signed [TRIG_FRAC_BITS+1:0] rot_sin,
	input  logic signed [COORD_BITS-1:0]     pos_x,
	input  logic signed [COORD_BITS-1:0]     pos_y,
	output logic signed [COORD_BITS-1:0]     rot_x,
	output logic signed [COORD_BITS-1:0]     rot_y
);

	localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;
	localparam int PROD_BITS = TRIG_BITS + COORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;

	logic signed [PROD_BITS-1:0] cx_s2, sy_s2, sx_s2, cy_s2;
	logic signed [SUM_BITS-1:0]  cx_e, sy_e, sx_e, cy_e;
	logic signed [SUM_BITS-1:0]  sum_x, sum_y, shr_x, shr_y;
	logic signed [COORD_BITS-1:0] rot_x_s3, rot_y_s3;

	// The value fits when every bit from the coordinate sign upward agrees.
	function automatic logic [COORD_BITS-1:0] sat_coord(input logic [SUM_BITS-1:0] v);
		logic [SUM_BITS-COORD_BITS:0] upper;
		logic [COORD_BITS-1:0]        res;
		upper = v[SUM_BITS-1:COORD_BITS-1];
		if ((&upper) || !(|upper)) begin
			res = v[COORD_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			res = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			res = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cx_s2 <= rot_cos * pos_x;
			sy_s2 <= rot_sin * pos_y;
			sx_s2 <= rot_sin * pos_x;
			cy_s2 <= rot_cos * pos_y;
		end
	end

	assign cx_e = {cx_s2[PROD_BITS-1], cx_s2};
	assign sy_e = {sy_s2[PROD_BITS-1], sy_s2};
	assign sx_e = {sx_s2[PROD_BITS-1], sx_s2};
	assign cy_e = {cy_s2[PROD_BITS-1], cy_s2};

	assign sum_x = cx_e - sy_e;
	assign sum_y = sx_e + cy_e;

	// An arithmetic right shift of a two's complement value rounds toward minus infinity.
	assign shr_x = sum_x >>> TRIG_FRAC_BITS;
	assign shr_y = sum_y >>> TRIG_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rot_x_s3 <= sat_coord(shr_x);
			rot_y_s3 <= sat_coord(shr_y);
		end
	end

	assign rot_x = rot_x_s3;
	assign rot_y = rot_y_s3;

endmodule

### src/point_rotate_crop_filter_unit.sv
// ----------------------------------------------------------------------------
// point_rotate_crop_filter_unit
// Rotates lidar points about z and flags those that pass the strength threshold,
// lie inside the configured crop box and lie outside the inner band.
//   Channel  Role    Payload
//   point    sink    pos_x, pos_y, pos_z, strength
//   result   source  rot_x, rot_y, out_z, keep
//   cfg      sink    index, wdata (register write, always ready)
//
// One point is accepted per clock cycle while the result side does not stall;
// each point passes in order through the input register, the product register,
// the rotate register and the output register.
// Reset clears every stage valid bit and loads the registers with their
// defaults. A stalled result holds only the stages behind it that are full;
// empty stages keep accepting.
// ----------------------------------------------------------------------------
`include "point_rotate_crop_filter_unit_assert.svh"

module point_rotate_crop_filter_unit
	import prcf_pkg::*;
#(
	parameter int COORD_BITS     = 24,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	prcf_point_if.sink   point,
	prcf_result_if.source result,
	prcf_cfg_if.sink     cfg
);

	localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;

	// Configuration registers.
	logic        [INTEN_BITS-1:0] intensity_min_q;
	logic signed [TRIG_BITS-1:0]  rotation_cos_q;
	logic signed [TRIG_BITS-1:0]  rotation_sin_q;
	logic        [COORD_BITS-2:0] x_limit_q;
	logic signed [COORD_BITS-1:0] y_low_q;
	logic signed [COORD_BITS-1:0] y_high_q;
	logic signed [COORD_BITS-1:0] inner_top_q;
	logic signed [COORD_BITS-1:0] inner_bot_q;

	// Pipeline.
	logic                         valid_s1, valid_s2, valid_s3;
	logic signed [COORD_BITS-1:0] pos_x_s1, pos_y_s1, pos_z_s1, pos_z_s2, pos_z_s3;
	logic        [INTEN_BITS-1:0] strength_s1, strength_s2, strength_s3;
	logic signed [COORD_BITS-1:0] rot_x_s3, rot_y_s3;
	logic                         ready_s1, ready_s2, ready_s3, out_free;
	stage_en_t                    rot_en;

	// Output register.
	logic                         res_valid_q;
	logic signed [COORD_BITS-1:0] rot_x_q, rot_y_q, out_z_q;
	logic                         keep_q;

	// Window tests.
	logic signed [COORD_BITS:0] rx_e, xl_e;
	logic                       x_ok, y_ok, inner_hit, inten_ok, keep_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_min_q <= '0;
			rotation_cos_q  <= TRIG_BITS'(1) << TRIG_FRAC_BITS;
			rotation_sin_q  <= '0;
			x_limit_q       <= '1;
			y_low_q         <= {1'b1, {(COORD_BITS-1){1'b0}}};
			y_high_q        <= {1'b0, {(COORD_BITS-1){1'b1}}};
			inner_top_q     <= '0;
			inner_bot_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_INTENSITY_MIN: intensity_min_q <= cfg.wdata[INTEN_BITS-1:0];
				REG_ROTATION_COS:  rotation_cos_q  <= cfg.wdata[TRIG_BITS-1:0];
				REG_ROTATION_SIN:  rotation_sin_q  <= cfg.wdata[TRIG_BITS-1:0];
				REG_X_LIMIT:       x_limit_q       <= cfg.wdata[COORD_BITS-2:0];
				REG_Y_LOW:         y_low_q         <= cfg.wdata[COORD_BITS-1:0];
				REG_Y_HIGH:        y_high_q        <= cfg.wdata[COORD_BITS-1:0];
				REG_INNER_TOP:     inner_top_q     <= cfg.wdata[COORD_BITS-1:0];
				REG_INNER_BOT:     inner_bot_q     <= cfg.wdata[COORD_BITS-1:0];
			endcase
		end
	end

	// A stage may load when it is empty or its contents move on this cycle.
	assign out_free = !res_valid_q || result.ready;
	assign ready_s3 = !valid_s3 || out_free;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign point.ready = ready_s1;

	assign rot_en.s2 = valid_s1 && ready_s2;
	assign rot_en.s3 = valid_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= point.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (point.valid && ready_s1) begin
			pos_x_s1    <= point.pos_x;
			pos_y_s1    <= point.pos_y;
			pos_z_s1    <= point.pos_z;
			strength_s1 <= point.strength;
		end
		if (rot_en.s2) begin
			pos_z_s2    <= pos_z_s1;
			strength_s2 <= strength_s1;
		end
		if (rot_en.s3) begin
			pos_z_s3    <= pos_z_s2;
			strength_s3 <= strength_s2;
		end
		if (valid_s3 && out_free) begin
			rot_x_q <= rot_x_s3;
			rot_y_q <= rot_y_s3;
			out_z_q <= pos_z_s3;
			keep_q  <= keep_d;
		end
	end

	prcf_rotate #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_rotate (
		.clk     (clk),
		.en      (rot_en),
		.rot_cos (rotation_cos_q),
		.rot_sin (rotation_sin_q),
		.pos_x   (pos_x_s1),
		.pos_y   (pos_y_s1),
		.rot_x   (rot_x_s3),
		.rot_y   (rot_y_s3)
	);

	// The x test runs one bit wider so that the negated limit always fits.
	assign rx_e      = {rot_x_s3[COORD_BITS-1], rot_x_s3};
	assign xl_e      = {2'b00, x_limit_q};
	assign x_ok      = (rx_e <= xl_e) && (rx_e >= -xl_e);
	assign y_ok      = (rot_y_s3 >= y_low_q) && (rot_y_s3 <= y_high_q);
	assign inner_hit = (rot_y_s3 < inner_top_q) && (rot_y_s3 > inner_bot_q);
	assign inten_ok  = strength_s3 >= intensity_min_q;
	assign keep_d    = inten_ok && x_ok && y_ok && !inner_hit;

	assign result.valid = res_valid_q;
	assign result.rot_x = rot_x_q;
	assign result.rot_y = rot_y_q;
	assign result.out_z = out_z_q;
	assign result.keep  = keep_q;

	`PRCF_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, point.valid && point.ready, valid_s1)
	`PRCF_ASSERT_NEXT(a_s1_moves_to_s2, clk, arst_n, valid_s1 && ready_s2, valid_s2)
	`PRCF_ASSERT_NEXT(a_s3_reaches_out, clk, arst_n, valid_s3 && out_free, result.valid)
	`PRCF_ASSERT_NEXT(a_stall_holds_s3, clk, arst_n, result.valid && !result.ready && valid_s3, valid_s3)
	`PRCF_ASSERT_SAME(a_empty_out_ready, clk, arst_n, !result.valid, point.ready)

endmodule

### tb/sv/crop_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crop_filter_checker
// Watches the point, result and register write channels of the rotate and
// crop filter. It keeps its own copy of the registers, predicts the rotated
// point and keep flag of each point transfer, and compares every result
// transfer, field by field, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module crop_filter_checker
	import prcf_pkg::*;
#(
	parameter int COORD_BITS     = 24,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	prcf_point_if  point,
	prcf_result_if result,
	prcf_cfg_if    cfg,
	output int     fail_count,
	output int     pending
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t rot_x;
		coord_t rot_y;
		coord_t out_z;
		logic   keep;
	} filtered_point_t;

	logic [INTEN_BITS-1:0]           min_strength;
	logic signed [TRIG_FRAC_BITS+1:0] cos_q;
	logic signed [TRIG_FRAC_BITS+1:0] sin_q;
	logic [COORD_BITS-2:0]           x_half;
	coord_t                          y_floor;
	coord_t                          y_ceil;
	coord_t                          band_top;
	coord_t                          band_bot;

	filtered_point_t expected_points[$];

	function automatic longint saturate_coord(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic filtered_point_t predict_rotated_point(coord_t px, coord_t py, coord_t pz,
			logic [INTEN_BITS-1:0] strength);
		longint xs, ys, rx, ry, xl, ylo, yhi, itop, ibot;
		filtered_point_t p;
		xs   = px;
		ys   = py;
		xl   = longint'(x_half);
		ylo  = y_floor;
		yhi  = y_ceil;
		itop = band_top;
		ibot = band_bot;
		// An arithmetic right shift of a signed product rounds toward minus infinity.
		rx = saturate_coord((longint'(cos_q) * xs - longint'(sin_q) * ys) >>> TRIG_FRAC_BITS);
		ry = saturate_coord((longint'(sin_q) * xs + longint'(cos_q) * ys) >>> TRIG_FRAC_BITS);
		p.rot_x = coord_t'(rx);
		p.rot_y = coord_t'(ry);
		p.out_z = pz;
		p.keep  = (strength >= min_strength) && (rx >= -xl) && (rx <= xl)
			&& (ry >= ylo) && (ry <= yhi) && !((ry < itop) && (ry > ibot));
		return p;
	endfunction

	task automatic compare_field(input string name, input coord_t want, input coord_t got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_point_t exp_p;
		if (!arst_n) begin
			min_strength = '0;
			cos_q        = (TRIG_FRAC_BITS + 2)'(1) << TRIG_FRAC_BITS;
			sin_q        = '0;
			x_half       = '1;
			y_floor      = {1'b1, {(COORD_BITS-1){1'b0}}};
			y_ceil       = {1'b0, {(COORD_BITS-1){1'b1}}};
			band_top     = '0;
			band_bot     = '0;
			fail_count   = 0;
			expected_points.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_INTENSITY_MIN: min_strength = cfg.wdata[INTEN_BITS-1:0];
					REG_ROTATION_COS:  cos_q        = cfg.wdata[TRIG_FRAC_BITS+1:0];
					REG_ROTATION_SIN:  sin_q        = cfg.wdata[TRIG_FRAC_BITS+1:0];
					REG_X_LIMIT:       x_half       = cfg.wdata[COORD_BITS-2:0];
					REG_Y_LOW:         y_floor      = cfg.wdata[COORD_BITS-1:0];
					REG_Y_HIGH:        y_ceil       = cfg.wdata[COORD_BITS-1:0];
					REG_INNER_TOP:     band_top     = cfg.wdata[COORD_BITS-1:0];
					REG_INNER_BOT:     band_bot     = cfg.wdata[COORD_BITS-1:0];
					default: ;
				endcase
			end
			if (point.valid && point.ready) begin
				expected_points.insert(expected_points.size(),
					predict_rotated_point(point.pos_x, point.pos_y,
					point.pos_z, point.strength));
			end
			if (result.valid && result.ready) begin
				if (expected_points.size() == 0) begin
					fail_count++;
					$error("result transfer with no point outstanding");
				end else begin
					exp_p = expected_points.pop_front();
					compare_field("rot_x", exp_p.rot_x, result.rot_x);
					compare_field("rot_y", exp_p.rot_y, result.rot_y);
					compare_field("out_z", exp_p.out_z, result.out_z);
					compare_field("keep", coord_t'(exp_p.keep), coord_t'(result.keep));
				end
			end
		end
		pending = expected_points.size();
	end

endmodule

### tb/sv/point_rotate_crop_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_crop_filter_unit_tb
// Drives lidar points and register writes into the rotate and crop filter
// with random gaps and random result stalls. A directed part covers the
// coordinate extremes, saturation, floor rounding, the strength threshold and
// the box and band edges; random phases then run under random register
// settings. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module point_rotate_crop_filter_unit_tb;
	import prcf_pkg::*;

	localparam int COORD_BITS     = 24;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_POINTS   = 140;
	localparam int NEAR_SPAN      = 1 << 20;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	logic idle_free = 1'b0;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;

	prcf_point_if  #(.COORD_BITS(COORD_BITS)) point_ch ();
	prcf_result_if #(.COORD_BITS(COORD_BITS)) result_ch ();
	prcf_cfg_if    #(.DATA_BITS(COORD_BITS))  cfg_ch ();

	point_rotate_crop_filter_unit #(
		.COORD_BITS    (COORD_BITS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.point (point_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	crop_filter_checker #(
		.COORD_BITS    (COORD_BITS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point_ch),
		.result    (result_ch),
		.cfg       (cfg_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: a fresh random stall, possibly none, before every transfer unless idle_free is set.
	initial begin
		int gap;
		result_ch.ready = 1'b0;
		forever begin
			gap = idle_free ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
		end
	end

	task automatic send_point(coord_t x, coord_t y, coord_t z, logic [INTEN_BITS-1:0] strength);
		int gap;
		gap = idle_free ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap != 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point_ch.valid    <= 1'b1;
		point_ch.pos_x    <= x;
		point_ch.pos_y    <= y;
		point_ch.pos_z    <= z;
		point_ch.strength <= strength;
		do @(posedge clk); while (point_ch.ready !== 1'b1);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [COORD_BITS-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop sending and let the pipeline empty before registers change.
	task automatic drain();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return coord_t'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return coord_t'(int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
		endcase
	endfunction

	// Upper bits beyond a register's width are filled at random; the block drops them.
	function automatic logic [COORD_BITS-1:0] pick_reg_value(cfg_reg_t idx);
		int v;
		case (idx)
			REG_INTENSITY_MIN: begin
				case ($urandom_range(0, 3))
					0: v = 0;
					1: v = 16'hFFFF;
					default: v = $urandom_range(0, 16'h4000);
				endcase
				return {8'($urandom), 16'(v)};
			end
			REG_ROTATION_COS, REG_ROTATION_SIN: begin
				case ($urandom_range(0, 5))
					0: v = 16384;
					1: v = -16384;
					2: v = 0;
					3: v = $urandom;
					default: v = int'($urandom_range(0, 32768)) - 16384;
				endcase
				return {8'($urandom), 16'(v)};
			end
			REG_X_LIMIT: begin
				case ($urandom_range(0, 3))
					0: v = 0;
					1: v = 23'h7FFFFF;
					default: v = $urandom_range(0, 1 << 21);
				endcase
				return {1'($urandom), 23'(v)};
			end
			REG_Y_LOW: begin
				case ($urandom_range(0, 3))
					0: v = -(1 << 23);
					1: v = $urandom;
					default: v = -int'($urandom_range(0, 1 << 21));
				endcase
				return 24'(v);
			end
			REG_Y_HIGH: begin
				case ($urandom_range(0, 3))
					0: v = (1 << 23) - 1;
					1: v = $urandom;
					default: v = $urandom_range(0, 1 << 21);
				endcase
				return 24'(v);
			end
			REG_INNER_TOP: begin
				case ($urandom_range(0, 3))
					0: v = $urandom;
					1: v = -int'($urandom_range(0, 1 << 18));
					default: v = $urandom_range(0, 1 << 18);
				endcase
				return 24'(v);
			end
			REG_INNER_BOT: begin
				case ($urandom_range(0, 3))
					0: v = $urandom;
					default: v = -int'($urandom_range(0, 1 << 18));
				endcase
				return 24'(v);
			end
			default: return '0;
		endcase
	endfunction

	initial begin
		arst_n            = 1'b0;
		point_ch.valid    = 1'b0;
		point_ch.pos_x    = '0;
		point_ch.pos_y    = '0;
		point_ch.pos_z    = '0;
		point_ch.strength = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_INTENSITY_MIN;
		cfg_ch.wdata      = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: identity rotation; the box holds every point but one whose x is the coordinate minimum.
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000);
		send_point(coord_t'(0), coord_t'(0), coord_t'(0), 16'h0000);
		send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), 16'h8000);
		drain();

		// Half-turn plus eighth-turn scaled so that x' = y - x and y' = -x - y.
		// The upper write bits are junk that the registers must drop.
		write_reg(REG_INTENSITY_MIN, 24'hAB1000);
		write_reg(REG_ROTATION_COS, 24'hFFC000);
		write_reg(REG_ROTATION_SIN, 24'hFFC000);
		write_reg(REG_X_LIMIT, 24'h8003E8);
		write_reg(REG_Y_LOW, -24'sd2000);
		write_reg(REG_Y_HIGH, 24'sd2000);
		write_reg(REG_INNER_TOP, 24'sd500);
		write_reg(REG_INNER_BOT, -24'sd500);
		send_point(coord_t'(-250), coord_t'(-250), coord_t'(7), 16'h1000);
		send_point(coord_t'(-250), coord_t'(-250), coord_t'(7), 16'h0FFF);
		send_point(coord_t'(-300), coord_t'(300), coord_t'(8), 16'hFFFF);
		send_point(coord_t'(-1000), coord_t'(0), coord_t'(9), 16'hFFFF);
		send_point(coord_t'(-1001), coord_t'(0), coord_t'(10), 16'hFFFF);
		send_point(coord_t'(1000), coord_t'(0), coord_t'(11), 16'hFFFF);
		send_point(coord_t'(-1000), coord_t'(-1000), coord_t'(12), 16'hFFFF);
		send_point(coord_t'(-1000), coord_t'(-1001), coord_t'(13), 16'hFFFF);
		send_point(COORD_MIN, COORD_MIN, coord_t'(14), 16'hFFFF);
		send_point(COORD_MAX, COORD_MIN, coord_t'(15), 16'hFFFF);
		drain();

		// Out-of-range trig values, an inverted y band and an empty inner band.
		write_reg(REG_INTENSITY_MIN, 24'h000000);
		write_reg(REG_ROTATION_COS, 24'h007FFF);
		write_reg(REG_ROTATION_SIN, 24'h008000);
		write_reg(REG_X_LIMIT, 24'h7FFFFF);
		write_reg(REG_Y_LOW, 24'sd100);
		write_reg(REG_Y_HIGH, -24'sd100);
		write_reg(REG_INNER_TOP, -24'sd10);
		write_reg(REG_INNER_BOT, 24'sd10);
		send_point(coord_t'(1), coord_t'(1), coord_t'(1), 16'h0001);
		send_point(coord_t'(0), coord_t'(0), coord_t'(0), 16'h0000);
		send_point(coord_t'(-1), coord_t'(0), coord_t'(-5), 16'h7FFF);
		send_point(COORD_MAX, COORD_MAX, COORD_MIN, 16'hFFFF);
		send_point(COORD_MIN, COORD_MAX, COORD_MAX, 16'hFFFF);
		send_point(coord_t'(100), coord_t'(-3), coord_t'(3), 16'h1234);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				write_reg(cfg_reg_t'(r), pick_reg_value(cfg_reg_t'(r)));
			end
			for (int n = 0; n < PHASE_POINTS; n++) begin
				if (n % 20 == 0) begin
					idle_free = ($urandom_range(0, 3) == 0);
				end
				send_point(rand_coord(), rand_coord(), coord_t'($urandom), 16'($urandom));
			end
			idle_free = 1'b0;
			drain();
		end

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
